// ----- rtl/hoct_pkg.sv -----
`default_nettype none

package hoct_pkg;

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned SLOT_W = 6;
  localparam int unsigned IP_W   = 32;
  localparam int unsigned PORT_W = 16;
  localparam int unsigned SEQ_W  = 32;
  localparam int unsigned MAC_W  = 48;
  localparam int unsigned KEY_W  = 2 * IP_W + 2 * PORT_W;
  localparam int unsigned DATA_W = 2 * SEQ_W + MAC_W;

  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_MISS = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic clear;  // zero one valid entry, advance index
    logic start;  // capture request, restart scan
    logic scan;   // read entry at index, advance index
    logic act;    // table update for the captured request
    logic load;   // move result into the response register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last;   // index points at the final entry
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- rtl/hoct_if.sv -----
`default_nettype none

interface hoct_req_if;
  logic                         valid;
  logic                         ready;
  logic [hoct_pkg::CMD_W-1:0]   command;
  logic [hoct_pkg::IP_W-1:0]    src_ip;
  logic [hoct_pkg::IP_W-1:0]    dst_ip;
  logic [hoct_pkg::PORT_W-1:0]  tcp_sport;
  logic [hoct_pkg::PORT_W-1:0]  tcp_dport;
  logic [hoct_pkg::SEQ_W-1:0]   initial_send_seq;
  logic [hoct_pkg::SEQ_W-1:0]   receive_next;
  logic [hoct_pkg::MAC_W-1:0]   remote_mac;

  modport source (
    output valid, command, src_ip, dst_ip, tcp_sport, tcp_dport,
           initial_send_seq, receive_next, remote_mac,
    input  ready
  );
  modport sink (
    input  valid, command, src_ip, dst_ip, tcp_sport, tcp_dport,
           initial_send_seq, receive_next, remote_mac,
    output ready
  );
endinterface

interface hoct_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [hoct_pkg::ST_W-1:0]    status;
  logic [hoct_pkg::SLOT_W-1:0]  slot;
  logic [hoct_pkg::SEQ_W-1:0]   found_send_seq;
  logic [hoct_pkg::SEQ_W-1:0]   found_receive_next;
  logic [hoct_pkg::MAC_W-1:0]   found_peer_mac;

  modport source (
    output valid, status, slot, found_send_seq, found_receive_next, found_peer_mac,
    input  ready
  );
  modport sink (
    input  valid, status, slot, found_send_seq, found_receive_next, found_peer_mac,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/hoct_ctrl.sv -----
`default_nettype none

module hoct_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output hoct_pkg::ctrl_cmd_t      cmd_o,
  input  wire hoct_pkg::dp_sts_t   sts_i
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_DRAIN = 6'b001000,
    S_ACT   = 6'b010000,
    S_RESP  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.last) state_d = S_DRAIN;
      end
      // compare of the final entry happens here
      S_DRAIN: state_d = S_ACT;
      S_ACT: begin
        cmd_o.act = 1'b1;
        state_d   = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          cmd_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_SCAN))
    else $error("accepted request did not start a scan");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> (!out_valid_q || out_ready_i))
    else $error("response overwritten before it was taken");

  a_scan_ends_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && sts_i.last) |=> (state_q == S_DRAIN))
    else $error("scan did not stop at the final entry");

  a_act_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.act |-> $past(state_q == S_DRAIN))
    else $error("table update issued without a finished scan");
`endif

endmodule

`default_nettype wire

// ----- rtl/hoct_dp.sv -----
`default_nettype none

module hoct_dp #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire hoct_pkg::ctrl_cmd_t            cmd_i,
  output hoct_pkg::dp_sts_t                   sts_o,
  input  wire logic [hoct_pkg::CMD_W-1:0]     command_i,
  input  wire logic [hoct_pkg::IP_W-1:0]      src_ip_i,
  input  wire logic [hoct_pkg::IP_W-1:0]      dst_ip_i,
  input  wire logic [hoct_pkg::PORT_W-1:0]    tcp_sport_i,
  input  wire logic [hoct_pkg::PORT_W-1:0]    tcp_dport_i,
  input  wire logic [hoct_pkg::SEQ_W-1:0]     initial_send_seq_i,
  input  wire logic [hoct_pkg::SEQ_W-1:0]     receive_next_i,
  input  wire logic [hoct_pkg::MAC_W-1:0]     remote_mac_i,
  output logic [hoct_pkg::ST_W-1:0]           status_o,
  output logic [hoct_pkg::SLOT_W-1:0]         slot_o,
  output logic [hoct_pkg::SEQ_W-1:0]          found_send_seq_o,
  output logic [hoct_pkg::SEQ_W-1:0]          found_receive_next_o,
  output logic [hoct_pkg::MAC_W-1:0]          found_peer_mac_o
);

  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [AW-1:0] LastIdx = AW'(TABLE_ENTRIES - 1);
  localparam int unsigned KW = hoct_pkg::KEY_W;
  localparam int unsigned DW = hoct_pkg::DATA_W;
  localparam int unsigned SW = hoct_pkg::SEQ_W;
  localparam int unsigned MW = hoct_pkg::MAC_W;

  // table stores
  logic          valid_mem [TABLE_ENTRIES];
  logic [KW-1:0] key_mem   [TABLE_ENTRIES];
  logic [DW-1:0] data_mem  [TABLE_ENTRIES];

  // captured request
  logic [hoct_pkg::CMD_W-1:0] cmd_q;
  logic [KW-1:0]              key_q;
  logic [DW-1:0]              data_q;

  logic [AW-1:0] cnt_q, cnt_d;
  logic          rd_vld_q;
  logic [AW-1:0] rd_idx_q;
  logic          rd_valid_q;
  logic [KW-1:0] rd_key_q;
  logic [DW-1:0] rd_data_q;

  logic          hit_q, hit_d;
  logic [AW-1:0] hit_idx_q;
  logic [DW-1:0] hit_data_q;
  logic          free_q, free_d;
  logic [AW-1:0] free_idx_q;

  logic          entry_hit, take_hit, take_free;
  logic          is_alloc, is_del, alloc_new;
  logic          vld_we, vld_wd, key_we, data_we;
  logic [AW-1:0] wr_idx;

  logic [hoct_pkg::ST_W-1:0]   res_status;
  logic [hoct_pkg::SLOT_W-1:0] res_slot;
  logic [DW-1:0]               res_data;

  assign sts_o.last = (cnt_q == LastIdx);

  // compare stage, one entry per cycle behind the read
  assign entry_hit = rd_valid_q && (rd_key_q == key_q);
  assign take_hit  = rd_vld_q && entry_hit && !hit_q;
  assign take_free = rd_vld_q && !rd_valid_q && !free_q;

  always_comb begin
    cnt_d  = cnt_q;
    hit_d  = hit_q;
    free_d = free_q;
    if (cmd_i.start) begin
      cnt_d  = '0;
      hit_d  = 1'b0;
      free_d = 1'b0;
    end else begin
      if (cmd_i.clear || cmd_i.scan) cnt_d = cnt_q + 1'b1;
      if (take_hit)  hit_d  = 1'b1;
      if (take_free) free_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
      free_q   <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      rd_vld_q <= cmd_i.scan;
      hit_q    <= hit_d;
      free_q   <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      cmd_q  <= command_i;
      key_q  <= {src_ip_i, dst_ip_i, tcp_sport_i, tcp_dport_i};
      data_q <= {initial_send_seq_i, receive_next_i, remote_mac_i};
    end
    if (cmd_i.scan) rd_idx_q <= cnt_q;
    if (take_hit) begin
      hit_idx_q  <= rd_idx_q;
      hit_data_q <= rd_data_q;
    end
    if (take_free) free_idx_q <= rd_idx_q;
  end

  // table update
  assign is_alloc  = cmd_i.act && (cmd_q == hoct_pkg::CMD_ALLOC);
  assign is_del    = cmd_i.act && (cmd_q == hoct_pkg::CMD_DELETE);
  assign alloc_new = is_alloc && !hit_q && free_q;
  assign vld_we    = cmd_i.clear || alloc_new || (is_del && hit_q);
  assign vld_wd    = is_alloc;
  assign key_we    = alloc_new;
  assign data_we   = is_alloc && (hit_q || free_q);
  assign wr_idx    = cmd_i.clear ? cnt_q : (hit_q ? hit_idx_q : free_idx_q);

  always_ff @(posedge clk_i) begin
    if (vld_we) valid_mem[wr_idx] <= vld_wd;
    rd_valid_q <= valid_mem[cnt_q];
  end

  always_ff @(posedge clk_i) begin
    if (key_we) key_mem[wr_idx] <= key_q;
    rd_key_q <= key_mem[cnt_q];
  end

  always_ff @(posedge clk_i) begin
    if (data_we) data_mem[wr_idx] <= data_q;
    rd_data_q <= data_mem[cnt_q];
  end

  // result
  always_comb begin
    res_status = hoct_pkg::ST_MISS;
    res_slot   = '0;
    res_data   = '0;
    case (cmd_q)
      hoct_pkg::CMD_LOOKUP: begin
        if (hit_q) begin
          res_status = hoct_pkg::ST_OK;
          res_slot   = hoct_pkg::SLOT_W'(hit_idx_q);
          res_data   = hit_data_q;
        end
      end
      hoct_pkg::CMD_ALLOC: begin
        if (hit_q) begin
          res_status = hoct_pkg::ST_OK;
          res_slot   = hoct_pkg::SLOT_W'(hit_idx_q);
        end else if (free_q) begin
          res_status = hoct_pkg::ST_OK;
          res_slot   = hoct_pkg::SLOT_W'(free_idx_q);
        end else begin
          res_status = hoct_pkg::ST_FULL;
        end
      end
      hoct_pkg::CMD_DELETE: begin
        if (hit_q) begin
          res_status = hoct_pkg::ST_OK;
          res_slot   = hoct_pkg::SLOT_W'(hit_idx_q);
        end
      end
      default: res_status = hoct_pkg::ST_MISS;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      status_o             <= res_status;
      slot_o               <= res_slot;
      found_send_seq_o     <= res_data[DW-1 -: SW];
      found_receive_next_o <= res_data[MW +: SW];
      found_peer_mac_o     <= res_data[MW-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/half_open_connection_table.sv -----
// Channel | Dir | Handshake     | Payload
// req_i   | in  | valid / ready | command, four-tuple key, ISS, receive-next, peer MAC
// rsp_o   | out | valid / ready | status, slot, found ISS, receive-next, peer MAC
//
// A response is valid once a linear scan has read one table entry per cycle through the
// single read port, the final entry has been compared and the table has been updated.
// A new request is not taken until the previous one is loaded into the response register.
// After reset the valid store is swept clear, entry by entry; no request is
// accepted during that sweep. req_i.ready is high only while idle; a waiting response
// holds in its register while the next request may be accepted and scanned meanwhile.
`default_nettype none

module half_open_connection_table #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  hoct_req_if.sink   req_i,
  hoct_rsp_if.source rsp_o
);

  hoct_pkg::ctrl_cmd_t cmd;
  hoct_pkg::dp_sts_t   sts;

  hoct_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  hoct_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .command_i            (req_i.command),
    .src_ip_i             (req_i.src_ip),
    .dst_ip_i             (req_i.dst_ip),
    .tcp_sport_i          (req_i.tcp_sport),
    .tcp_dport_i          (req_i.tcp_dport),
    .initial_send_seq_i   (req_i.initial_send_seq),
    .receive_next_i       (req_i.receive_next),
    .remote_mac_i         (req_i.remote_mac),
    .status_o             (rsp_o.status),
    .slot_o               (rsp_o.slot),
    .found_send_seq_o     (rsp_o.found_send_seq),
    .found_receive_next_o (rsp_o.found_receive_next),
    .found_peer_mac_o     (rsp_o.found_peer_mac)
  );

endmodule

`default_nettype wire

// ----- tb/half_open_connection_table_tb.sv -----
`timescale 1ns / 100ps

module half_open_connection_table_tb;

  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned RANDOM_ITEMS  = 1550;
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  localparam logic [hoct_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef logic [hoct_pkg::KEY_W-1:0] key_t;
  typedef logic [hoct_pkg::MAC_W-1:0] mac_t;

  typedef struct {
    logic [hoct_pkg::CMD_W-1:0]  command;
    logic [hoct_pkg::IP_W-1:0]   src_ip;
    logic [hoct_pkg::IP_W-1:0]   dst_ip;
    logic [hoct_pkg::PORT_W-1:0] tcp_sport;
    logic [hoct_pkg::PORT_W-1:0] tcp_dport;
    logic [hoct_pkg::SEQ_W-1:0]  iss;
    logic [hoct_pkg::SEQ_W-1:0]  rcv_nxt;
    mac_t                        mac;
  } conn_req_t;

  typedef struct {
    logic [hoct_pkg::ST_W-1:0]   status;
    logic [hoct_pkg::SLOT_W-1:0] slot;
    logic [hoct_pkg::SEQ_W-1:0]  send_seq;
    logic [hoct_pkg::SEQ_W-1:0]  rcv_nxt;
    mac_t                        mac;
  } conn_rsp_t;

  typedef enum int unsigned {MODE_FILL, MODE_MIX, MODE_DRAIN} gen_mode_e;
  typedef enum int unsigned {
    ACT_ALLOC_NEW, ACT_ALLOC_AGAIN, ACT_LOOKUP_LIVE, ACT_LOOKUP_NEAR,
    ACT_DELETE_LIVE, ACT_DELETE_NEAR, ACT_UNUSED
  } gen_act_e;

  logic clk_i;
  logic rst_ni;
  logic calm = 1'b0;

  hoct_req_if req_if ();
  hoct_rsp_if rsp_if ();

  half_open_connection_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // shadow of the connection table
  logic                       conn_valid  [TABLE_ENTRIES];
  key_t                       shadow_key  [TABLE_ENTRIES];
  logic [hoct_pkg::SEQ_W-1:0] conn_iss    [TABLE_ENTRIES];
  logic [hoct_pkg::SEQ_W-1:0] conn_rnxt   [TABLE_ENTRIES];
  mac_t                       conn_mac    [TABLE_ENTRIES];

  conn_req_t   pending_reqs [$];
  conn_rsp_t   expected_rsps[$];
  key_t        live_keys    [$];
  conn_req_t   cur_req;
  int unsigned send_gap;
  int unsigned recv_stall;
  int unsigned reqs_total;
  int unsigned reqs_accepted = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;

  function automatic conn_rsp_t table_update(conn_req_t r);
    key_t      k;
    int        hit;
    int        free_idx;
    int        idx;
    conn_rsp_t rsp;
    k = {r.src_ip, r.dst_ip, r.tcp_sport, r.tcp_dport};
    hit = -1;
    free_idx = -1;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (hit < 0 && conn_valid[i] && shadow_key[i] == k) hit = i;
      if (free_idx < 0 && !conn_valid[i]) free_idx = i;
    end
    rsp = '{status: hoct_pkg::ST_MISS, default: '0};
    case (r.command)
      hoct_pkg::CMD_LOOKUP: begin
        if (hit >= 0) begin
          rsp.status   = hoct_pkg::ST_OK;
          rsp.slot     = hoct_pkg::SLOT_W'(hit);
          rsp.send_seq = conn_iss[hit];
          rsp.rcv_nxt  = conn_rnxt[hit];
          rsp.mac      = conn_mac[hit];
        end
      end
      hoct_pkg::CMD_ALLOC: begin
        idx = hit;
        if (idx < 0 && free_idx >= 0) begin
          idx = free_idx;
          conn_valid[idx] = 1'b1;
          shadow_key[idx] = k;
        end
        if (idx >= 0) begin
          conn_iss[idx]  = r.iss;
          conn_rnxt[idx] = r.rcv_nxt;
          conn_mac[idx]  = r.mac;
          rsp.status     = hoct_pkg::ST_OK;
          rsp.slot       = hoct_pkg::SLOT_W'(idx);
        end else begin
          rsp.status = hoct_pkg::ST_FULL;
        end
      end
      hoct_pkg::CMD_DELETE: begin
        if (hit >= 0) begin
          conn_valid[hit] = 1'b0;
          rsp.status      = hoct_pkg::ST_OK;
          rsp.slot        = hoct_pkg::SLOT_W'(hit);
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 140);
  endfunction

  function automatic void push_req(logic [hoct_pkg::CMD_W-1:0] cmd, key_t k,
                                   logic [hoct_pkg::SEQ_W-1:0] iss,
                                   logic [hoct_pkg::SEQ_W-1:0] rnxt, mac_t mac);
    conn_req_t r;
    r.command = cmd;
    {r.src_ip, r.dst_ip, r.tcp_sport, r.tcp_dport} = k;
    r.iss     = iss;
    r.rcv_nxt = rnxt;
    r.mac     = mac;
    pending_reqs.push_back(r);
  endfunction

  function automatic mac_t rand_mac();
    return mac_t'({$urandom, $urandom});
  endfunction

  function automatic void gen_one(gen_mode_e mode);
    int unsigned r;
    int unsigned pick;
    gen_act_e    act;
    key_t        k;
    key_t        live;
    key_t        near;
    logic [hoct_pkg::CMD_W-1:0] cmd;
    r = $urandom_range(0, 99);
    k = key_t'({$urandom, $urandom, $urandom});
    pick = 0;
    case (mode)
      MODE_FILL:
        act = r < 80 ? ACT_ALLOC_NEW : r < 90 ? ACT_LOOKUP_LIVE :
              r < 95 ? ACT_ALLOC_AGAIN : ACT_LOOKUP_NEAR;
      MODE_MIX:
        act = r < 30 ? ACT_LOOKUP_LIVE : r < 40 ? ACT_LOOKUP_NEAR :
              r < 55 ? ACT_ALLOC_NEW : r < 65 ? ACT_ALLOC_AGAIN :
              r < 85 ? ACT_DELETE_LIVE : r < 95 ? ACT_DELETE_NEAR : ACT_UNUSED;
      default:
        act = r < 65 ? ACT_DELETE_LIVE : r < 80 ? ACT_LOOKUP_LIVE :
              r < 90 ? ACT_LOOKUP_NEAR : r < 95 ? ACT_DELETE_NEAR : ACT_ALLOC_NEW;
    endcase
    if (live_keys.size() != 0) begin
      pick = $urandom_range(0, live_keys.size() - 1);
      live = live_keys[pick];
    end else begin
      live = k;
    end
    // one flipped key bit: partial match against a stored connection
    near = live ^ (key_t'(1) << $urandom_range(0, hoct_pkg::KEY_W - 1));
    case (act)
      ACT_ALLOC_NEW: begin
        cmd = hoct_pkg::CMD_ALLOC;
        if (live_keys.size() < TABLE_ENTRIES) live_keys.push_back(k);
      end
      ACT_ALLOC_AGAIN: begin
        cmd = hoct_pkg::CMD_ALLOC;
        if (live_keys.size() == 0) live_keys.push_back(k);
        k = live;
      end
      ACT_LOOKUP_LIVE: begin
        cmd = hoct_pkg::CMD_LOOKUP;
        k = live;
      end
      ACT_LOOKUP_NEAR: begin
        cmd = hoct_pkg::CMD_LOOKUP;
        k = near;
      end
      ACT_DELETE_LIVE: begin
        cmd = hoct_pkg::CMD_DELETE;
        k = live;
        if (live_keys.size() != 0) live_keys.delete(pick);
      end
      ACT_DELETE_NEAR: begin
        cmd = hoct_pkg::CMD_DELETE;
        k = near;
      end
      default: begin
        cmd = CMD_UNUSED;
        if (r[0]) k = live;
      end
    endcase
    push_req(cmd, k, $urandom, $urandom, rand_mac());
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatch_cnt++;
    end
  endfunction

  task automatic drive_req(conn_req_t r);
    req_if.command          <= r.command;
    req_if.src_ip           <= r.src_ip;
    req_if.dst_ip           <= r.dst_ip;
    req_if.tcp_sport        <= r.tcp_sport;
    req_if.tcp_dport        <= r.tcp_dport;
    req_if.initial_send_seq <= r.iss;
    req_if.receive_next     <= r.rcv_nxt;
    req_if.remote_mac       <= r.mac;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // long stretches with no idling on either side
  always @(posedge clk_i) begin
    if ($urandom_range(0, 399) == 0) calm <= ~calm;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    conn_req_t nxt;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      send_gap     <= 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        expected_rsps.push_back(table_update(cur_req));
        reqs_accepted++;
      end
      if (req_if.valid && !req_if.ready) begin
        // hold the request until taken
      end else if (send_gap != 0) begin
        req_if.valid <= 1'b0;
        send_gap     <= send_gap - 1;
      end else if (pending_reqs.size() != 0) begin
        nxt = pending_reqs.pop_front();
        cur_req = nxt;
        drive_req(nxt);
        req_if.valid <= 1'b1;
        send_gap     <= calm ? 0 : idle_len();
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // response monitor
  always @(posedge clk_i or negedge rst_ni) begin
    conn_rsp_t want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      recv_stall   <= 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected response: expected none, actual status %0d slot %0d",
                   $time, rsp_if.status, rsp_if.slot);
          mismatch_cnt++;
        end else begin
          want = expected_rsps.pop_front();
          check_field("status", 64'(want.status), 64'(rsp_if.status));
          check_field("slot", 64'(want.slot), 64'(rsp_if.slot));
          check_field("found_send_seq", 64'(want.send_seq), 64'(rsp_if.found_send_seq));
          check_field("found_receive_next", 64'(want.rcv_nxt),
                      64'(rsp_if.found_receive_next));
          check_field("found_peer_mac", 64'(want.mac), 64'(rsp_if.found_peer_mac));
        end
      end
      if (recv_stall != 0) begin
        rsp_if.ready <= 1'b0;
        recv_stall   <= recv_stall - 1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        rsp_if.ready <= 1'b0;
        recv_stall   <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 120)
                                                     : $urandom_range(0, 3);
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    key_t      key_a;
    gen_mode_e mode;
    int unsigned r;
    int unsigned run_len;

    rst_ni = 1'b0;
    req_if.valid            = 1'b0;
    req_if.command          = hoct_pkg::CMD_LOOKUP;
    req_if.src_ip           = '0;
    req_if.dst_ip           = '0;
    req_if.tcp_sport        = '0;
    req_if.tcp_dport        = '0;
    req_if.initial_send_seq = '0;
    req_if.receive_next     = '0;
    req_if.remote_mac       = '0;
    rsp_if.ready            = 1'b0;
    for (int i = 0; i < TABLE_ENTRIES; i++) conn_valid[i] = 1'b0;

    key_a = {32'hFFFF_FFFF, 32'h0000_0000, 16'h0000, 16'hFFFF};
    // empty table: misses and the unused command
    push_req(hoct_pkg::CMD_LOOKUP, '0, '0, '0, '0);
    push_req(hoct_pkg::CMD_DELETE, '1, '0, '0, '0);
    push_req(CMD_UNUSED, '0, '1, '1, '1);
    // extremes of key and data
    push_req(hoct_pkg::CMD_ALLOC, '0, '0, '0, '0);
    push_req(hoct_pkg::CMD_ALLOC, '1, '1, '1, '1);
    push_req(hoct_pkg::CMD_LOOKUP, '0, '1, '1, '1);
    push_req(hoct_pkg::CMD_LOOKUP, '1, '0, '0, '0);
    // retransmitted SYN rewrites the same slot
    push_req(hoct_pkg::CMD_ALLOC, '1, 32'h1234_5678, 32'h9ABC_DEF0, 48'h0246_8ACE_1357);
    push_req(hoct_pkg::CMD_LOOKUP, '1, '0, '0, '0);
    push_req(hoct_pkg::CMD_ALLOC, key_a, $urandom, $urandom, rand_mac());
    push_req(hoct_pkg::CMD_LOOKUP, key_a ^ key_t'(1), '0, '0, '0);
    push_req(hoct_pkg::CMD_LOOKUP, key_a, '0, '0, '0);
    push_req(hoct_pkg::CMD_DELETE, '0, '0, '0, '0);
    push_req(hoct_pkg::CMD_LOOKUP, '0, '0, '0, '0);
    push_req(hoct_pkg::CMD_DELETE, '0, '0, '0, '0);
    // lowest free slot is reused
    push_req(hoct_pkg::CMD_ALLOC, ~key_a, $urandom, $urandom, rand_mac());
    push_req(CMD_UNUSED, key_a, '1, '1, '1);
    push_req(hoct_pkg::CMD_LOOKUP, key_a, '0, '0, '0);
    push_req(hoct_pkg::CMD_DELETE, '1, '0, '0, '0);
    push_req(hoct_pkg::CMD_DELETE, key_a, '0, '0, '0);
    push_req(hoct_pkg::CMD_DELETE, ~key_a, '0, '0, '0);

    reqs_total = pending_reqs.size() + RANDOM_ITEMS;
    while (pending_reqs.size() < reqs_total) begin
      r = $urandom_range(0, 99);
      mode = r < 40 ? MODE_FILL : r < 75 ? MODE_MIX : MODE_DRAIN;
      run_len = $urandom_range(40, 110);
      for (int n = 0; n < run_len && pending_reqs.size() < reqs_total; n++) gen_one(mode);
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (reqs_accepted == reqs_total);
    wait (expected_rsps.size() == 0);
    repeat (2 * TABLE_ENTRIES + 8) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_rsps.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
